// ===== design/iir_tdf2_pkg.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_pkg
// Shared types and constants of the transposed direct form II IIR filter:
// item codes, the microcode control word and the program ROM.
// ----------------------------------------------------------------------------
package iir_tdf2_pkg;

   // fixed field widths of the channels and the taps reset value
   localparam int MODE_BITS  = 2;
   localparam int IDX_BITS   = 5;
   localparam int TAPS_BITS  = 6;
   localparam int TAPS_RESET = 32;

   // item codes carried in the mode field
   typedef enum logic [MODE_BITS-1:0] {
      MODE_FILTER   = 2'd0,
      MODE_LOAD_NUM = 2'd1,
      MODE_LOAD_DEN = 2'd2
   } mode_type;

   // program steps
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_B0,
      ST_ACC_D0,
      ST_OUT,
      ST_MUL_B,
      ST_MUL_A,
      ST_TAIL
   } step_type;

   // multiplier operand selection
   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_BX,
      MUL_AY
   } mul_sel_type;

   // tap counter operation
   typedef enum logic [1:0] {
      K_HOLD,
      K_ZERO,
      K_INC
   } k_op_type;

   // jump conditions
   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_START,
      COND_OUT_FREE,
      COND_LAST
   } cond_type;

   // one control word of the program
   typedef struct packed {
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        dly_write;
      logic        y_load;
      k_op_type    k_op;
      cond_type    cond;
      step_type    jump_step;
      step_type    seq_step;
   } uword_type;

   // status fed back to the sequencer
   typedef struct packed {
      logic start;
      logic out_free;
      logic last;
   } status_type;

   // program ROM: jump_step when the condition holds, seq_step otherwise
   function automatic uword_type ucode(input step_type step);
      uword_type w;
      w = '{mul_sel: MUL_NONE, acc_load: 1'b0, dly_write: 1'b0, y_load: 1'b0,
            k_op: K_HOLD, cond: COND_ALWAYS, jump_step: ST_IDLE, seq_step: ST_IDLE};
      case (step)
         ST_IDLE: begin
            w.k_op      = K_ZERO;
            w.cond      = COND_START;
            w.jump_step = ST_MUL_B0;
            w.seq_step  = ST_IDLE;
         end
         ST_MUL_B0: begin
            w.mul_sel   = MUL_BX;
            w.jump_step = ST_ACC_D0;
         end
         ST_ACC_D0: begin
            w.acc_load  = 1'b1;
            w.jump_step = ST_OUT;
         end
         ST_OUT: begin
            w.y_load    = 1'b1;
            w.k_op      = K_INC;
            w.cond      = COND_OUT_FREE;
            w.jump_step = ST_MUL_B;
            w.seq_step  = ST_OUT;
         end
         ST_MUL_B: begin
            w.mul_sel   = MUL_BX;
            w.dly_write = 1'b1;
            w.jump_step = ST_MUL_A;
         end
         ST_MUL_A: begin
            w.mul_sel   = MUL_AY;
            w.acc_load  = 1'b1;
            w.k_op      = K_INC;
            w.cond      = COND_LAST;
            w.jump_step = ST_TAIL;
            w.seq_step  = ST_MUL_B;
         end
         ST_TAIL: begin
            w.dly_write = 1'b1;
            w.jump_step = ST_IDLE;
         end
         default: begin
            w.jump_step = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== design/iir_tdf2_req_if.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_req_if
// Input channel: one word is a filter sample or a coefficient load.
// ----------------------------------------------------------------------------
interface iir_tdf2_req_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 24
);
   import iir_tdf2_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [MODE_BITS-1:0]          mode;
   logic [IDX_BITS-1:0]           coef_index;
   logic signed [COEF_BITS-1:0]   coef_value;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, mode, coef_index, coef_value, sample_in, input ready);
   modport sink   (input valid, mode, coef_index, coef_value, sample_in, output ready);
endinterface

// ===== design/iir_tdf2_rsp_if.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_rsp_if
// Result channel: one filtered sample and its clip flag per word.
// ----------------------------------------------------------------------------
interface iir_tdf2_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          saturated;

   modport source (output valid, sample_out, saturated, input ready);
   modport sink   (input valid, sample_out, saturated, output ready);
endinterface

// ===== design/iir_tdf2_csr_if.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_csr_if
// Configuration write channel for the taps register.
// ----------------------------------------------------------------------------
interface iir_tdf2_csr_if;
   import iir_tdf2_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [TAPS_BITS-1:0] taps_in_use;

   modport source (output valid, taps_in_use, input ready);
   modport sink   (input valid, taps_in_use, output ready);
endinterface

// ===== design/iir_tdf2_ram.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module iir_tdf2_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/iir_tdf2_useq.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_useq
// Microcode sequencer: step register, program ROM lookup and jump logic.
// ----------------------------------------------------------------------------
module iir_tdf2_useq (
   input  logic                     clock,
   input  logic                     reset,
   input  iir_tdf2_pkg::status_type status,
   output iir_tdf2_pkg::uword_type  ctl,
   output logic                     idle
);
   import iir_tdf2_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   uword_type uw;
   logic      take;
   logic      commit;

   assign uw = ucode(step_ff);

   // evaluate the jump condition
   always_comb begin
      case (uw.cond)
         COND_ALWAYS:   take = 1'b1;
         COND_START:    take = status.start;
         COND_OUT_FREE: take = status.out_free;
         COND_LAST:     take = status.last;
         default:       take = 1'b1;
      endcase
   end

   // next step
   always_comb begin
      step_in = take ? uw.jump_step : uw.seq_step;
   end

   // control outputs: hold the output step's actions until the result slot frees
   always_comb begin
      commit = (uw.cond != COND_OUT_FREE) || status.out_free;
      ctl    = uw;
      if (!commit) begin
         ctl.y_load = 1'b0;
         ctl.k_op   = K_HOLD;
      end
      idle = (step_ff == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end
endmodule

// ===== design/iir_tdf2_dpath.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_dpath
// Datapath: coefficient and delay memories, shared multiplier, accumulator,
// output rounding and saturation, tap counter.
// ----------------------------------------------------------------------------
module iir_tdf2_dpath #(
   parameter int MAX_TAPS    = 32,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  iir_tdf2_pkg::uword_type               ctl,
   input  logic                                  load_num,
   input  logic                                  load_den,
   input  logic                                  x_load,
   input  logic [iir_tdf2_pkg::IDX_BITS-1:0]     coef_index,
   input  logic signed [COEF_BITS-1:0]           coef_value,
   input  logic signed [SAMPLE_BITS-1:0]         sample_in,
   input  logic                                  dly_clear,
   input  logic [iir_tdf2_pkg::TAPS_BITS-1:0]    taps,
   output logic                                  last,
   output logic signed [SAMPLE_BITS-1:0]         y_out,
   output logic                                  y_sat
);
   import iir_tdf2_pkg::*;

   localparam int AW         = $clog2(MAX_TAPS);
   localparam int KW         = $clog2(MAX_TAPS + 1);
   localparam int PW         = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_RAW    = SAMPLE_BITS + COEF_BITS + 8;
   localparam int ACC_BITS   = (ACC_RAW > 60) ? 60 : ACC_RAW;
   localparam int SW         = ACC_BITS + 2;
   localparam int FRAC_SHIFT = COEF_BITS - 4;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_SHIFT - 1);

   logic [KW-1:0]                 k_ff, k_in;
   logic [KW-1:0]                 n_eff;
   logic [AW-1:0]                 rd_idx;
   logic [AW-1:0]                 coef_addr;
   logic                          coef_ok;
   logic [MAX_TAPS-1:0]           num_vld_ff, den_vld_ff, dly_vld_ff;
   logic [COEF_BITS-1:0]          b_rd, a_rd;
   logic [ACC_BITS-1:0]           d_rd;
   logic signed [COEF_BITS-1:0]   b_val, a_val, m_c;
   logic signed [SAMPLE_BITS-1:0] m_s;
   logic signed [ACC_BITS-1:0]    d_val;
   logic                          d_used;
   logic signed [SAMPLE_BITS-1:0] x_ff, y_ff;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [SW-1:0]          acc_ff, acc_in;
   logic signed [SW-1:0]          prod_ext, diff, rnd, shifted;
   logic                          dly_we;
   logic [AW-1:0]                 dly_waddr;
   logic [ACC_BITS-1:0]           dly_wdata;

   // clamp the taps register to the supported range
   always_comb begin
      if (taps < TAPS_BITS'(2)) begin
         n_eff = KW'(2);
      end else if (32'(taps) > MAX_TAPS) begin
         n_eff = KW'(MAX_TAPS);
      end else begin
         n_eff = KW'(taps);
      end
   end

   // tap counter; memories are read at its next value
   always_comb begin
      case (ctl.k_op)
         K_ZERO:  k_in = '0;
         K_INC:   k_in = k_ff + KW'(1);
         default: k_in = k_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   assign rd_idx = k_ff[AW-1:0];
   assign last   = ((k_ff + KW'(1)) == n_eff);
   assign d_used = (({1'b0, k_ff} + (KW + 1)'(2)) <= {1'b0, n_eff});

   // coefficient loads
   assign coef_ok   = (32'(coef_index) < MAX_TAPS);
   assign coef_addr = AW'(coef_index);

   iir_tdf2_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_num_ram (
      .clock (clock),
      .we    (load_num && coef_ok),
      .waddr (coef_addr),
      .wdata (coef_value),
      .raddr (k_in[AW-1:0]),
      .rdata (b_rd)
   );

   iir_tdf2_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_den_ram (
      .clock (clock),
      .we    (load_den && coef_ok),
      .waddr (coef_addr),
      .wdata (coef_value),
      .raddr (k_in[AW-1:0]),
      .rdata (a_rd)
   );

   iir_tdf2_ram #(.WIDTH(ACC_BITS), .DEPTH(MAX_TAPS)) u_dly_ram (
      .clock (clock),
      .we    (dly_we),
      .waddr (dly_waddr),
      .wdata (dly_wdata),
      .raddr (k_in[AW-1:0]),
      .rdata (d_rd)
   );

   // valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         num_vld_ff <= '0;
         den_vld_ff <= '0;
      end else begin
         if (load_num && coef_ok) begin
            num_vld_ff[coef_addr] <= 1'b1;
         end
         if (load_den && coef_ok) begin
            den_vld_ff[coef_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || dly_clear) begin
         dly_vld_ff <= '0;
      end else if (dly_we) begin
         dly_vld_ff[dly_waddr] <= 1'b1;
      end
   end

   assign b_val = num_vld_ff[rd_idx] ? $signed(b_rd) : '0;
   assign a_val = den_vld_ff[rd_idx] ? $signed(a_rd) : '0;
   assign d_val = (dly_vld_ff[rd_idx] && d_used) ? $signed(d_rd) : '0;

   // shared multiplier
   assign m_c     = (ctl.mul_sel == MUL_AY) ? a_val : b_val;
   assign m_s     = (ctl.mul_sel == MUL_AY) ? y_ff : x_ff;
   assign prod_in = {{SAMPLE_BITS{m_c[COEF_BITS-1]}}, m_c}
                  * {{COEF_BITS{m_s[SAMPLE_BITS-1]}}, m_s};

   // accumulate product and delay element
   assign prod_ext = {{(SW - PW){prod_ff[PW-1]}}, prod_ff};
   assign acc_in   = prod_ext + {{(SW - ACC_BITS){d_val[ACC_BITS-1]}}, d_val};

   always_ff @(posedge clock) begin
      if (ctl.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (ctl.acc_load) begin
         acc_ff <= acc_in;
      end
      if (x_load) begin
         x_ff <= sample_in;
      end
      if (ctl.y_load) begin
         y_ff <= y_out;
      end
   end

   // delay update: subtract the feedback product, saturate, write two taps back
   assign diff      = acc_ff - prod_ext;
   assign dly_we    = ctl.dly_write && (k_ff > KW'(1));
   assign dly_waddr = AW'(k_ff - KW'(2));

   always_comb begin
      if ((&diff[SW-1:ACC_BITS-1]) || !(|diff[SW-1:ACC_BITS-1])) begin
         dly_wdata = diff[ACC_BITS-1:0];
      end else begin
         dly_wdata = {diff[SW-1], {(ACC_BITS - 1){~diff[SW-1]}}};
      end
   end

   // output: round half up, then saturate
   assign rnd     = acc_ff + HALF;
   assign shifted = rnd >>> FRAC_SHIFT;

   always_comb begin
      if ((&shifted[SW-1:SAMPLE_BITS-1]) || !(|shifted[SW-1:SAMPLE_BITS-1])) begin
         y_out = shifted[SAMPLE_BITS-1:0];
         y_sat = 1'b0;
      end else begin
         y_out = {shifted[SW-1], {(SAMPLE_BITS - 1){~shifted[SW-1]}}};
         y_sat = 1'b1;
      end
   end
endmodule

// ===== design/iir_filter_transposed_df2.sv =====
// ----------------------------------------------------------------------------
// iir_filter_transposed_df2
// Transposed direct form II IIR filter, run by a microcoded sequencer over
// one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  takes one word per item: mode 0 filters sample_in, mode 1 and 2
//             load a numerator or denominator coefficient at coef_index.
//             Loads and mode 3 give no result; loads leave the sequencer idle.
//   rsp_chan  gives one word per filter item: sample_out and saturated.
//   csr_chan  writes taps_in_use (filter order plus one, clamped to 2 and
//             MAX_TAPS); every write clears the delay line. Write only idle.
//   A filter item runs the b0, d0 and output steps, then a b and an a product
//   on the single multiplier for taps 1 to N-1, N the clamped count, and tail.
//   The output step offers the result; the delay update runs on after it.
//   When rsp_chan stalls the finished result waits in the output register
//   and the next item still starts; its own result waits at the output step.
//   Reset clears coefficients and delay line to zero and sets taps to 32.
// ----------------------------------------------------------------------------
module iir_filter_transposed_df2 #(
   parameter int MAX_TAPS    = 32,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 24
) (
   input logic           clock,
   input logic           reset,
   iir_tdf2_req_if.sink   req_chan,
   iir_tdf2_rsp_if.source rsp_chan,
   iir_tdf2_csr_if.sink   csr_chan
);
   import iir_tdf2_pkg::*;

   logic                          idle;
   logic                          req_fire;
   logic                          csr_fire;
   uword_type                     ctl;
   status_type                    status;
   logic                          last;
   logic signed [SAMPLE_BITS-1:0] y_out;
   logic                          y_sat;
   logic [TAPS_BITS-1:0]          taps_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] sample_out_ff;
   logic                          saturated_ff;

   // handshakes
   assign req_chan.ready = idle;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;

   assign status.start    = req_fire && (req_chan.mode == MODE_FILTER);
   assign status.out_free = !rsp_valid_ff || rsp_chan.ready;
   assign status.last     = last;

   // taps register
   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= TAPS_BITS'(TAPS_RESET);
      end else if (csr_fire) begin
         taps_ff <= csr_chan.taps_in_use;
      end
   end

   iir_tdf2_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl),
      .idle   (idle)
   );

   iir_tdf2_dpath #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .load_num   (req_fire && (req_chan.mode == MODE_LOAD_NUM)),
      .load_den   (req_fire && (req_chan.mode == MODE_LOAD_DEN)),
      .x_load     (status.start),
      .coef_index (req_chan.coef_index),
      .coef_value (req_chan.coef_value),
      .sample_in  (req_chan.sample_in),
      .dly_clear  (csr_fire),
      .taps       (taps_ff),
      .last       (last),
      .y_out      (y_out),
      .y_sat      (y_sat)
   );

   // output register: load a finished word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.y_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.y_load) begin
         sample_out_ff <= y_out;
         saturated_ff  <= y_sat;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = sample_out_ff;
   assign rsp_chan.saturated  = saturated_ff;
endmodule

// ===== sim/iir_tdf2_checker.sv =====
// ----------------------------------------------------------------------------
// iir_tdf2_checker
// Watches the request, result and taps channels of the IIR filter, keeps its
// own fixed-point copy of the filter state and compares every result word
// with the oldest predicted word.
// ----------------------------------------------------------------------------
module iir_tdf2_checker #(
   parameter int MAX_TAPS    = 32,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 24
) (
   input  logic    clock,
   input  logic    reset,
   iir_tdf2_req_if req_mon,
   iir_tdf2_rsp_if rsp_mon,
   iir_tdf2_csr_if csr_mon,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import iir_tdf2_pkg::*;

   localparam int ACC_RAW   = SAMPLE_BITS + COEF_BITS + 8;
   localparam int ACC_BITS  = (ACC_RAW > 60) ? 60 : ACC_RAW;
   localparam int FRAC_BITS = COEF_BITS - 4;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          clipped;
   } filtered_word_type;

   filtered_word_type           filtered_queue[$];
   filtered_word_type           oldest;
   logic signed [COEF_BITS-1:0] num_coef [MAX_TAPS];
   logic signed [COEF_BITS-1:0] den_coef [MAX_TAPS];
   logic signed [ACC_BITS-1:0]  delay_acc [MAX_TAPS];
   logic [TAPS_BITS-1:0]        taps_reg;
   int                          mismatches = 0;

   assign fail_count = mismatches;

   // saturate to a signed range of w bits, flag when clipped
   function automatic longint clip_to(input longint v, input int w, inout logic hit);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // tap count after clamping to 2 .. MAX_TAPS
   function automatic int active_taps();
      int n;
      n = int'(taps_reg);
      if (n < 2) n = 2;
      if (n > MAX_TAPS) n = MAX_TAPS;
      return n;
   endfunction

   // one sample through the transposed structure, delay line updated in place
   function automatic filtered_word_type filter_sample(
      input logic signed [SAMPLE_BITS-1:0] x_in);
      filtered_word_type res;
      longint            x;
      longint            y;
      longint            acc;
      logic              hit;
      logic              acc_hit;
      int                n;
      int                k;
      n       = active_taps();
      x       = longint'(x_in);
      hit     = 1'b0;
      acc_hit = 1'b0;
      acc     = longint'(num_coef[0]) * x + longint'(delay_acc[0]);
      // round half up, then clip to the sample range
      y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      y = clip_to(y, SAMPLE_BITS, hit);
      for (k = 0; k + 2 < n; k++) begin
         acc = longint'(num_coef[k+1]) * x + longint'(delay_acc[k+1])
               - longint'(den_coef[k+1]) * y;
         delay_acc[k] = ACC_BITS'(clip_to(acc, ACC_BITS, acc_hit));
      end
      acc = longint'(num_coef[n-1]) * x - longint'(den_coef[n-1]) * y;
      delay_acc[n-2] = ACC_BITS'(clip_to(acc, ACC_BITS, acc_hit));
      res.sample  = y[SAMPLE_BITS-1:0];
      res.clipped = hit;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         // hold the reset state
         for (int i = 0; i < MAX_TAPS; i++) begin
            num_coef[i]  = '0;
            den_coef[i]  = '0;
            delay_acc[i] = '0;
         end
         taps_reg = TAPS_BITS'(TAPS_RESET);
         filtered_queue.delete();
      end else begin
         // taps write: take the new count and clear the delay line
         if (csr_mon.valid && csr_mon.ready) begin
            taps_reg = csr_mon.taps_in_use;
            for (int i = 0; i < MAX_TAPS; i++) delay_acc[i] = '0;
         end
         // compare the result word with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (filtered_queue.size() == 0) begin
               $display("t=%0t unexpected result word: sample_out %0d saturated %0b",
                        $time, rsp_mon.sample_out, rsp_mon.saturated);
               mismatches++;
            end else begin
               oldest = filtered_queue.pop_front();
               if (rsp_mon.sample_out !== oldest.sample) begin
                  $display("t=%0t sample_out mismatch: expected %0d, actual %0d",
                           $time, oldest.sample, rsp_mon.sample_out);
                  mismatches++;
               end
               if (rsp_mon.saturated !== oldest.clipped) begin
                  $display("t=%0t saturated mismatch: expected %0b, actual %0b",
                           $time, oldest.clipped, rsp_mon.saturated);
                  mismatches++;
               end
            end
         end
         // request word: filter, load a coefficient, or drop
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.mode)
               MODE_FILTER: filtered_queue.push_back(filter_sample(req_mon.sample_in));
               MODE_LOAD_NUM: begin
                  if (int'(req_mon.coef_index) < MAX_TAPS)
                     num_coef[req_mon.coef_index] = req_mon.coef_value;
               end
               MODE_LOAD_DEN: begin
                  if (int'(req_mon.coef_index) < MAX_TAPS)
                     den_coef[req_mon.coef_index] = req_mon.coef_value;
               end
               default: begin
               end
            endcase
         end
      end
      pending = filtered_queue.size();
   end

endmodule

// ===== sim/iir_filter_transposed_df2_test.sv =====
// ----------------------------------------------------------------------------
// iir_filter_transposed_df2_test
// Stimulus for the transposed direct form II IIR filter: a directed pass over
// clipping, rounding, taps clamping and ignored words, then random phases of
// coefficient loads and sample streams at several tap counts and idle mixes,
// with one long result hold-off. Checking is done by iir_tdf2_checker.
// ----------------------------------------------------------------------------
module iir_filter_transposed_df2_test;
   timeunit 1ns;
   timeprecision 1ps;

   import iir_tdf2_pkg::*;

   localparam int MAX_TAPS      = 32;
   localparam int SAMPLE_BITS   = 16;
   localparam int COEF_BITS     = 24;
   localparam int ITEM_TARGET   = 1800;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 20;
   localparam int HOLD_CYCLES   = 600;

   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam logic signed [COEF_BITS-1:0]   COEF_UNITY = COEF_BITS'(1 << (COEF_BITS - 4));
   localparam logic signed [COEF_BITS-1:0]   COEF_HALF  = COEF_BITS'(1 << (COEF_BITS - 5));
   localparam logic signed [COEF_BITS-1:0]   COEF_QUART = COEF_BITS'(1 << (COEF_BITS - 6));

   logic clock;
   logic reset;
   int   src_idle_pct;
   int   rsp_stall_pct;
   bit   hold_wanted;
   int   item_total;
   int   fail_count;
   int   pending;
   int   cycle_count;

   iir_tdf2_req_if #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) req_chan ();
   iir_tdf2_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_chan ();
   iir_tdf2_csr_if csr_chan ();

   iir_filter_transposed_df2 #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   iir_tdf2_checker #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: end the run if it never drains
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      int hold_left;
      bit hold_served;
      hold_left      = 0;
      hold_served    = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // offer one request word, with random idle cycles in front of it
   task automatic offer_word(input logic [MODE_BITS-1:0]        m,
                             input logic [IDX_BITS-1:0]         idx,
                             input logic signed [COEF_BITS-1:0] cv,
                             input logic signed [SAMPLE_BITS-1:0] s);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= m;
      req_chan.coef_index <= idx;
      req_chan.coef_value <= cv;
      req_chan.sample_in  <= s;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (m != MODE_UNUSED) item_total++;
   endtask

   // wait until every result is out and the delay update has finished
   task automatic drain_block();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write the taps register while idle
   task automatic set_taps(input logic [TAPS_BITS-1:0] value);
      drain_block();
      csr_chan.valid       <= 1'b1;
      csr_chan.taps_in_use <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 19))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // full-range coefficient, or one within +/- span
   function automatic logic signed [COEF_BITS-1:0] pick_coef(input bit wide, input int span);
      int v;
      if (wide) return COEF_BITS'($urandom);
      v = int'($urandom_range(0, 2 * span)) - span;
      return COEF_BITS'(v);
   endfunction

   function automatic logic signed [COEF_BITS-1:0] any_coef();
      return COEF_BITS'($urandom);
   endfunction

   task automatic run_directed();
      // zero coefficients give silence at both extremes
      offer_word(MODE_FILTER, 5'd0, '0, SAMPLE_MAX);
      offer_word(MODE_FILTER, 5'd31, COEF_MAX, SAMPLE_MIN);
      // largest gain clips both ways
      offer_word(MODE_LOAD_NUM, 5'd0, COEF_MAX, '0);
      offer_word(MODE_FILTER, 5'd0, '0, SAMPLE_MAX);
      offer_word(MODE_FILTER, 5'd0, '0, SAMPLE_MIN);
      // leading denominator is stored but never used
      offer_word(MODE_LOAD_DEN, 5'd0, COEF_MIN, '0);
      // unused mode is dropped
      offer_word(MODE_UNUSED, 5'd31, COEF_MIN, SAMPLE_MAX);
      // extreme coefficients on the last tap
      offer_word(MODE_LOAD_NUM, 5'd31, COEF_MIN, '0);
      offer_word(MODE_LOAD_DEN, 5'd31, COEF_MAX, '0);
      offer_word(MODE_LOAD_NUM, 5'd0, COEF_UNITY, '0);
      offer_word(MODE_FILTER, 5'd0, '0, SAMPLE_BITS'(16384));
      offer_word(MODE_FILTER, 5'd0, '0, '0);
      offer_word(MODE_FILTER, 5'd0, '0, '1);
      // shortest filter; minus one at b0 = 0.5 rounds half up to zero
      set_taps(6'd2);
      offer_word(MODE_LOAD_NUM, 5'd0, COEF_HALF, '0);
      offer_word(MODE_LOAD_NUM, 5'd1, COEF_HALF, '0);
      offer_word(MODE_LOAD_DEN, 5'd1, -COEF_QUART, '0);
      offer_word(MODE_FILTER, 5'd0, '0, '1);
      offer_word(MODE_FILTER, 5'd0, '0, SAMPLE_MAX);
      // taps below 2 and above the maximum clamp; each write clears the delays
      set_taps(6'd0);
      offer_word(MODE_FILTER, 5'd0, '0, SAMPLE_BITS'(1));
      set_taps(6'd1);
      offer_word(MODE_FILTER, 5'd0, '0, SAMPLE_MIN);
      set_taps(6'd63);
      offer_word(MODE_FILTER, 5'd0, '0, SAMPLE_MAX);
      set_taps(6'd33);
      offer_word(MODE_FILTER, 5'd0, '0, SAMPLE_BITS'(1));
   endtask

   // one random phase: load a full coefficient set, then stream samples
   task automatic run_phase(input logic [TAPS_BITS-1:0] taps, input int idle_style,
                            input bit with_hold);
      int n;
      int k;
      int count;
      int roll;
      int a_span;
      bit wide;
      set_taps(taps);
      case (idle_style)
         0: begin src_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin src_idle_pct = 54; rsp_stall_pct = 0;  end
         2: begin src_idle_pct = 0;  rsp_stall_pct = 54; end
         default: begin src_idle_pct = 19; rsp_stall_pct = 19; end
      endcase
      // long result hold-off with the sender running flat out
      if (with_hold) begin
         src_idle_pct = 0;
         hold_wanted  = 1'b1;
      end
      n = int'(taps);
      if (n < 2) n = 2;
      if (n > MAX_TAPS) n = MAX_TAPS;
      wide   = ($urandom_range(0, 7) == 0);
      a_span = (1 << (COEF_BITS - 4)) / (2 * n);
      for (k = 0; k < n; k++) begin
         offer_word(MODE_LOAD_NUM, IDX_BITS'(k), pick_coef(wide, 1 << (COEF_BITS - 5)),
                    pick_sample());
         offer_word(MODE_LOAD_DEN, IDX_BITS'(k), pick_coef(wide, a_span), pick_sample());
      end
      count = $urandom_range(60, 140);
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 86) begin
            offer_word(MODE_FILTER, IDX_BITS'($urandom), any_coef(), pick_sample());
         end else if (roll < 93) begin
            offer_word(($urandom_range(0, 1) != 0) ? MODE_LOAD_NUM : MODE_LOAD_DEN,
                       IDX_BITS'($urandom_range(0, n - 1)), pick_coef(wide, a_span),
                       pick_sample());
         end else if (roll < 97) begin
            offer_word(MODE_UNUSED, IDX_BITS'($urandom), any_coef(), pick_sample());
         end else begin
            offer_word(($urandom_range(0, 1) != 0) ? MODE_LOAD_NUM : MODE_LOAD_DEN,
                       IDX_BITS'($urandom), any_coef(), pick_sample());
         end
      end
   endtask

   // main stimulus and verdict
   initial begin
      logic [TAPS_BITS-1:0] taps;
      int phase;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.mode        = MODE_FILTER;
      req_chan.coef_index  = '0;
      req_chan.coef_value  = '0;
      req_chan.sample_in   = '0;
      csr_chan.valid       = 1'b0;
      csr_chan.taps_in_use = TAPS_BITS'(TAPS_RESET);
      src_idle_pct         = 0;
      rsp_stall_pct        = 0;
      hold_wanted          = 1'b0;
      item_total           = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      item_total = 0;
      phase      = 0;
      while (item_total < ITEM_TARGET) begin
         case (phase)
            0: taps = 6'd32;
            1: taps = 6'd2;
            2: taps = 6'd0;
            3: taps = 6'd63;
            4: taps = 6'd1;
            5: taps = 6'd33;
            default: begin
               if ($urandom_range(0, 9) == 0) taps = TAPS_BITS'($urandom_range(0, 63));
               else taps = TAPS_BITS'($urandom_range(2, 10));
            end
         endcase
         run_phase(taps, phase % 4, phase == 4);
         phase++;
      end

      drain_block();
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
